>>> sv/ffsa_pkg.sv
// Shared types and codes for the first-fit segment allocator.
// Used by ffsa_mem, ffsa_mod and first_fit_segment_allocator_unit; depends on nothing.
package ffsa_pkg;

    localparam int unsigned OFS_W   = 28;
    localparam int unsigned ALIGN_W = 17;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_MERGE = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_NO_MEMORY = 2'd1,
        STS_NOT_FOUND = 2'd2
    } status_e_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_A_MOD,
        ST_A_PAD,
        ST_A_FIT,
        ST_P_TEST,
        ST_P_RD,
        ST_P_WR,
        ST_P_WA,
        ST_P_WB,
        ST_M_TEST,
        ST_M_RDA,
        ST_M_RDB,
        ST_M_CHK,
        ST_S_RD,
        ST_S_WR,
        ST_M_TAIL,
        ST_F_RD,
        ST_F_CHK,
        ST_RESP
    } state_e_t;

    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] length;
        logic             free;
    } frag_t;

endpackage

>>> sv/ffsa_mem.sv
// Fragment table storage: one write port, one read port with registered read data.
// Depends on ffsa_pkg for the fragment entry type.
module ffsa_mem #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  ffsa_pkg::frag_t wdata,
    input  logic [AW-1:0] raddr,
    output ffsa_pkg::frag_t rdata
);
    import ffsa_pkg::*;

    frag_t mem [DEPTH];
    frag_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/ffsa_mod.sv
// Iterative restoring remainder unit: fragment start modulo alignment, one bit a cycle.
// Depends on ffsa_pkg for field widths.
module ffsa_mod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ffsa_pkg::OFS_W-1:0]    dividend,
    input  logic [ffsa_pkg::ALIGN_W-1:0]  divisor,
    output logic                          done,
    output logic [ffsa_pkg::ALIGN_W-1:0]  remainder
);
    import ffsa_pkg::*;

    localparam int unsigned SW = $clog2(OFS_W + 1);

    logic [SW-1:0]      steps_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [OFS_W-1:0]   dvd_reg;
    logic [ALIGN_W-1:0] rem_reg;
    logic [ALIGN_W-1:0] div_reg;
    logic [ALIGN_W:0]   trial;

    assign trial = {rem_reg, dvd_reg[OFS_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            steps_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                steps_reg <= SW'(OFS_W);
            end else if (busy_reg) begin
                steps_reg <= steps_reg - 1'b1;
                if (steps_reg == SW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[OFS_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_reg <= ALIGN_W'(trial - {1'b0, div_reg});
            end else begin
                rem_reg <= trial[ALIGN_W-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> sv/first_fit_segment_allocator_unit.sv
// Top level of the first-fit segment allocator: sequencer, fragment counts and output register.
// Depends on ffsa_pkg, ffsa_mem and ffsa_mod.
//
// Commands arrive as beats on the s_ channel: tuser carries the command and the table
// select, tdata the request size, alignment and release offset. Every command beat gives
// exactly one result beat on the m_ channel with status, granted offset and granted size.
// Allocate walks the selected table one fragment at a time, reading each entry from the
// table memory, and waits on the remainder unit for each free fragment large enough to be
// tried. A split moves the tail of the table up one entry. A failed search coalesces both
// tables and searches again. Free walks the table one entry at a time; coalesce inspects
// neighbouring pairs and moves the entries behind each merged pair down one place. The
// block takes no new beat until the current command is finished. After reset the table
// memory is initialised with s_tready low.
// A finished result waits in the output register while m_tready is low; the next command
// may be accepted meanwhile, but its result is held until the register is free.
module first_fit_segment_allocator_unit #(
    parameter int unsigned MAX_FRAGMENTS     = 64,
    parameter int unsigned INITIAL_FRAGMENTS = 16,
    parameter int unsigned FRAGMENT_BYTES    = 16000000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // request_size, alignment, release_offset
    input  logic [2:0]  s_tuser,  // cmd, host_mappable
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // status, granted_offset, granted_size
);
    import ffsa_pkg::*;

    localparam int unsigned DEPTH = 2 * MAX_FRAGMENTS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(MAX_FRAGMENTS + 1);
    localparam int unsigned NINIT =
        (INITIAL_FRAGMENTS < MAX_FRAGMENTS) ? INITIAL_FRAGMENTS : MAX_FRAGMENTS;
    localparam logic [AW-1:0]    TBL1_BASE = AW'(MAX_FRAGMENTS);
    localparam logic [CW-1:0]    CNT_MAX   = CW'(MAX_FRAGMENTS);
    localparam logic [CW-1:0]    CNT_INIT  = CW'(NINIT);
    localparam logic [CW-1:0]    IDX_LAST  = CW'(MAX_FRAGMENTS - 1);
    localparam logic [OFS_W-1:0] FRAG_B    = OFS_W'(FRAGMENT_BYTES);

    function automatic logic [AW-1:0] tab_addr(input logic t, input logic [CW-1:0] idx);
        return (t ? TBL1_BASE : '0) + AW'(idx);
    endfunction

    state_e_t state_reg, state_next;

    logic               t_reg;
    cmd_e_t             cmd_reg;
    logic [OFS_W-1:0]   size_reg;
    logic [ALIGN_W-1:0] align_reg;
    logic [OFS_W-1:0]   rel_reg;
    logic               retry_reg;
    logic               mt_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      cnt_reg [2];
    logic [OFS_W-1:0]   cur_start_reg;
    logic [OFS_W-1:0]   cur_len_reg;
    logic [ALIGN_W-1:0] pad_reg;
    logic [OFS_W:0]     used_reg;
    frag_t              a_reg;
    status_e_t          status_reg;
    logic [OFS_W-1:0]   goff_reg;
    logic [OFS_W-1:0]   gsize_reg;
    logic               clr_t_reg;
    logic [CW-1:0]      clr_i_reg;
    logic [OFS_W-1:0]   clr_acc_reg;
    logic               m_valid_reg;
    logic [63:0]        m_data_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    frag_t              mem_wdata;
    logic [AW-1:0]      mem_raddr;
    frag_t              rd;
    logic               mod_start;
    logic               mod_done;
    logic [ALIGN_W-1:0] mod_rem;

    logic               s_fire;
    logic               out_free;
    logic [CW-1:0]      cnt_t;
    logic [CW-1:0]      cnt_mt;
    logic [CW:0]        i_inc;
    logic [CW:0]        k_inc;
    logic               split;
    logic               fits;
    logic               hit;
    logic [OFS_W:0]     rd_end;
    logic [ALIGN_W-1:0] in_align;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign cnt_t    = cnt_reg[t_reg];
    assign cnt_mt   = cnt_reg[mt_reg];
    assign i_inc    = {1'b0, i_reg} + 1'b1;
    assign k_inc    = {1'b0, k_reg} + 1'b1;
    assign fits     = used_reg <= {1'b0, cur_len_reg};
    assign split    = (used_reg < {2'b00, cur_len_reg[OFS_W-1:1]}) && (cnt_t < CNT_MAX);
    assign rd_end   = {1'b0, rd.start} + {1'b0, rd.length};
    assign hit      = !rd.free && (rel_reg >= rd.start) && ({1'b0, rel_reg} < rd_end);
    assign in_align = (s_tdata[44:28] == '0) ? ALIGN_W'(1) : s_tdata[44:28];

    ffsa_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd)
    );

    ffsa_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (rd.start),
        .divisor   (align_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_t_reg && clr_i_reg == IDX_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    case (cmd_e_t'(s_tuser[1:0]))
                        CMD_ALLOC: state_next = (s_tdata[27:0] == '0) ? ST_RESP : ST_A_RD;
                        CMD_FREE:  state_next = ST_F_RD;
                        CMD_MERGE: state_next = ST_M_TEST;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_A_RD: begin
                if (i_reg >= cnt_t) begin
                    state_next = retry_reg ? ST_RESP : ST_M_TEST;
                end else begin
                    state_next = ST_A_CHK;
                end
            end
            ST_A_CHK:  state_next = (!rd.free || rd.length < size_reg) ? ST_A_RD : ST_A_MOD;
            ST_A_MOD:  state_next = mod_done ? ST_A_PAD : ST_A_MOD;
            ST_A_PAD:  state_next = ST_A_FIT;
            ST_A_FIT: begin
                if (!fits) begin
                    state_next = ST_A_RD;
                end else if (split) begin
                    state_next = ST_P_TEST;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_P_TEST: state_next = ({1'b0, k_reg} > i_inc) ? ST_P_RD : ST_P_WA;
            ST_P_RD:   state_next = ST_P_WR;
            ST_P_WR:   state_next = ST_P_TEST;
            ST_P_WA:   state_next = ST_P_WB;
            ST_P_WB:   state_next = ST_RESP;
            ST_M_TEST: begin
                if (i_inc < {1'b0, cnt_mt}) begin
                    state_next = ST_M_RDA;
                end else if (!mt_reg) begin
                    state_next = ST_M_TEST;
                end else if (cmd_reg == CMD_ALLOC) begin
                    state_next = ST_A_RD;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_M_RDA:  state_next = ST_M_RDB;
            ST_M_RDB:  state_next = ST_M_CHK;
            ST_M_CHK:  state_next = (a_reg.free && rd.free) ? ST_S_RD : ST_M_TEST;
            ST_S_RD:   state_next = (k_inc < {1'b0, cnt_mt}) ? ST_S_WR : ST_M_TAIL;
            ST_S_WR:   state_next = ST_S_RD;
            ST_M_TAIL: state_next = ST_M_TEST;
            ST_F_RD:   state_next = (i_reg >= cnt_t) ? ST_RESP : ST_F_CHK;
            ST_F_CHK:  state_next = hit ? ST_RESP : ST_F_RD;
            ST_RESP:   state_next = out_free ? ST_IDLE : ST_RESP;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        mod_start = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = tab_addr(clr_t_reg, clr_i_reg);
                if (clr_i_reg < CNT_INIT) begin
                    mem_wdata = '{start: clr_acc_reg, length: FRAG_B, free: 1'b1};
                end
            end
            ST_A_RD:  mem_raddr = tab_addr(t_reg, i_reg);
            ST_A_CHK: mod_start = rd.free && (rd.length >= size_reg);
            ST_A_FIT: begin
                if (fits && !split) begin
                    mem_we    = 1'b1;
                    mem_waddr = tab_addr(t_reg, i_reg);
                    mem_wdata = '{start: cur_start_reg, length: cur_len_reg, free: 1'b0};
                end
            end
            ST_P_RD:  mem_raddr = tab_addr(t_reg, CW'(k_reg - 1'b1));
            ST_P_WR: begin
                mem_we    = 1'b1;
                mem_waddr = tab_addr(t_reg, k_reg);
                mem_wdata = rd;
            end
            ST_P_WA: begin
                mem_we    = 1'b1;
                mem_waddr = tab_addr(t_reg, i_reg);
                mem_wdata = '{start: cur_start_reg, length: used_reg[OFS_W-1:0], free: 1'b0};
            end
            ST_P_WB: begin
                mem_we    = 1'b1;
                mem_waddr = tab_addr(t_reg, i_inc[CW-1:0]);
                mem_wdata = '{start:  OFS_W'(cur_start_reg + used_reg[OFS_W-1:0]),
                              length: OFS_W'(cur_len_reg - used_reg[OFS_W-1:0]),
                              free:   1'b1};
            end
            ST_M_RDA: mem_raddr = tab_addr(mt_reg, i_reg);
            ST_M_RDB: mem_raddr = tab_addr(mt_reg, i_inc[CW-1:0]);
            ST_M_CHK: begin
                if (a_reg.free && rd.free) begin
                    mem_we    = 1'b1;
                    mem_waddr = tab_addr(mt_reg, i_reg);
                    mem_wdata = '{start:  a_reg.start,
                                  length: OFS_W'(a_reg.length + rd.length),
                                  free:   1'b1};
                end
            end
            ST_S_RD:  mem_raddr = tab_addr(mt_reg, k_inc[CW-1:0]);
            ST_S_WR: begin
                mem_we    = 1'b1;
                mem_waddr = tab_addr(mt_reg, k_reg);
                mem_wdata = rd;
            end
            ST_M_TAIL: begin
                mem_we    = 1'b1;
                mem_waddr = tab_addr(mt_reg, CW'(cnt_mt - 1'b1));
            end
            ST_F_RD:  mem_raddr = tab_addr(t_reg, i_reg);
            ST_F_CHK: begin
                if (hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = tab_addr(t_reg, i_reg);
                    mem_wdata = '{start: rd.start, length: rd.length, free: 1'b1};
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_t_reg   <= 1'b0;
            clr_i_reg   <= '0;
            clr_acc_reg <= '0;
            cnt_reg[0]  <= CNT_INIT;
            cnt_reg[1]  <= CNT_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (clr_i_reg == IDX_LAST) begin
                        clr_i_reg   <= '0;
                        clr_acc_reg <= '0;
                        clr_t_reg   <= 1'b1;
                    end else begin
                        clr_i_reg   <= clr_i_reg + 1'b1;
                        clr_acc_reg <= OFS_W'(clr_acc_reg + FRAG_B);
                    end
                end
                ST_P_WB:   cnt_reg[t_reg] <= cnt_t + 1'b1;
                ST_M_TAIL: cnt_reg[mt_reg] <= cnt_mt - 1'b1;
                default: begin
                    clr_t_reg <= clr_t_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cmd_reg    <= cmd_e_t'(s_tuser[1:0]);
                    t_reg      <= s_tuser[2];
                    size_reg   <= s_tdata[27:0];
                    align_reg  <= in_align;
                    rel_reg    <= s_tdata[72:45];
                    retry_reg  <= 1'b0;
                    mt_reg     <= 1'b0;
                    i_reg      <= '0;
                    goff_reg   <= '0;
                    gsize_reg  <= '0;
                    status_reg <= STS_DONE;
                    if (cmd_e_t'(s_tuser[1:0]) == CMD_ALLOC && s_tdata[27:0] == '0) begin
                        status_reg <= STS_NO_MEMORY;
                    end
                end
            end
            ST_A_RD: begin
                if (i_reg >= cnt_t) begin
                    if (retry_reg) begin
                        status_reg <= STS_NO_MEMORY;
                    end else begin
                        retry_reg <= 1'b1;
                        mt_reg    <= 1'b0;
                        i_reg     <= '0;
                    end
                end
            end
            ST_A_CHK: begin
                cur_start_reg <= rd.start;
                cur_len_reg   <= rd.length;
                if (!rd.free || rd.length < size_reg) begin
                    i_reg <= i_inc[CW-1:0];
                end
            end
            ST_A_MOD: begin
                if (mod_done) begin
                    pad_reg <= (mod_rem == '0) ? '0 : ALIGN_W'(align_reg - mod_rem);
                end
            end
            ST_A_PAD: used_reg <= {1'b0, size_reg} + (OFS_W + 1)'(pad_reg);
            ST_A_FIT: begin
                if (!fits) begin
                    i_reg <= i_inc[CW-1:0];
                end else begin
                    goff_reg  <= OFS_W'(cur_start_reg + OFS_W'(pad_reg));
                    gsize_reg <= size_reg;
                    k_reg     <= cnt_t;
                end
            end
            ST_P_WR: k_reg <= k_reg - 1'b1;
            ST_M_TEST: begin
                if (!(i_inc < {1'b0, cnt_mt})) begin
                    mt_reg <= 1'b1;
                    i_reg  <= '0;
                end
            end
            ST_M_RDB: a_reg <= rd;
            ST_M_CHK: begin
                if (a_reg.free && rd.free) begin
                    k_reg <= i_inc[CW-1:0];
                end else begin
                    i_reg <= i_inc[CW-1:0];
                end
            end
            ST_S_WR: k_reg <= k_inc[CW-1:0];
            ST_F_RD: begin
                if (i_reg >= cnt_t) begin
                    status_reg <= STS_NOT_FOUND;
                end
            end
            ST_F_CHK: begin
                if (!hit) begin
                    i_reg <= i_inc[CW-1:0];
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_data_reg <= {6'b0, gsize_reg, goff_reg, status_reg};
                end
            end
            default: begin
                a_reg <= a_reg;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg[0] <= CNT_MAX) && (cnt_reg[1] <= CNT_MAX))
        else $error("fragment count beyond table size");

    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg[1:0] != STS_DONE) |-> (m_data_reg[57:2] == '0))
        else $error("failed command reports a grant");

    a_split_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_P_WB) |-> (cnt_t < CNT_MAX))
        else $error("split into a full table");

    a_mod_only_in_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == ST_A_MOD))
        else $error("remainder finished outside of the fit check");

endmodule

>>> test/testbench.sv
// Testbench for first_fit_segment_allocator_unit: directed and random command beats with
// a scoreboard class holding its own copy of both fragment tables. Depends on ffsa_pkg.
timeunit 1ns;
timeprecision 1ps;

import ffsa_pkg::*;

typedef struct packed {
    status_e_t        status;
    logic [27:0]      offset;
    logic [27:0]      size;
} grant_t;

class allocator_scoreboard;
    localparam int NFRAG = 64;
    bit [27:0]   frag_base[2*NFRAG];
    bit [27:0]   frag_len[2*NFRAG];
    bit          frag_free[2*NFRAG];
    int unsigned frag_used[2];
    grant_t      pending_grants[$];
    int          errors, granted, no_memory, released, not_found, merges, checked;
    bit [27:0]   live_offsets[2][$];

    function new();
        for (int t = 0; t < 2; t++) begin
            for (int i = 0; i < NFRAG; i++) begin
                frag_base[t*NFRAG+i] = (i < 16) ? 28'(i * 16000000) : '0;
                frag_len[t*NFRAG+i]  = (i < 16) ? 28'd16000000 : '0;
                frag_free[t*NFRAG+i] = (i < 16);
            end
            frag_used[t] = 16;
        end
    endfunction

    function void join_free(int t);
        int b, i, a;
        b = t * NFRAG;
        i = 0;
        while (i + 1 < frag_used[t]) begin
            a = b + i;
            if (frag_free[a] && frag_free[a+1]) begin
                frag_len[a] = frag_len[a] + frag_len[a+1];
                for (int k = i + 1; k + 1 < frag_used[t]; k++) begin
                    frag_base[b+k] = frag_base[b+k+1];
                    frag_len[b+k]  = frag_len[b+k+1];
                    frag_free[b+k] = frag_free[b+k+1];
                end
                frag_used[t]--;
                frag_base[b+frag_used[t]] = '0;
                frag_len[b+frag_used[t]]  = '0;
                frag_free[b+frag_used[t]] = 0;
            end else begin
                i++;
            end
        end
    endfunction

    function bit place(int t, longint unsigned sz, longint unsigned al,
                       output longint unsigned off);
        int b, a;
        longint unsigned st, len, pad, need;
        b = t * NFRAG;
        off = 0;
        for (int i = 0; i < frag_used[t]; i++) begin
            a = b + i;
            st = frag_base[a];
            len = frag_len[a];
            if (!frag_free[a] || len < sz) continue;
            pad = (al - (st % al)) % al;
            need = sz + pad;
            if (need > len) continue;
            frag_free[a] = 0;
            off = st + pad;
            if (need < len / 2 && frag_used[t] < NFRAG) begin
                for (int k = frag_used[t]; k > i + 1; k--) begin
                    frag_base[b+k] = frag_base[b+k-1];
                    frag_len[b+k]  = frag_len[b+k-1];
                    frag_free[b+k] = frag_free[b+k-1];
                end
                frag_base[a+1] = 28'(st + need);
                frag_len[a+1]  = 28'(len - need);
                frag_free[a+1] = 1;
                frag_len[a]    = 28'(need);
                frag_used[t]++;
            end
            return 1;
        end
        return 0;
    endfunction

    function void note_command(cmd_e_t cmd, bit tbl, bit [27:0] sz, bit [16:0] al,
                               bit [27:0] rel);
        grant_t g;
        longint unsigned off, align;
        bit ok;
        g = '{STS_DONE, '0, '0};
        align = (al == 0) ? 1 : al;
        case (cmd)
            CMD_ALLOC: begin
                ok = 0;
                if (sz != 0) begin
                    ok = place(tbl, sz, align, off);
                    if (!ok) begin
                        join_free(0);
                        join_free(1);
                        ok = place(tbl, sz, align, off);
                    end
                end
                if (ok) begin
                    g.offset = 28'(off);
                    g.size = sz;
                    granted++;
                    live_offsets[tbl] = {live_offsets[tbl], 28'(off)};
                end else begin
                    g.status = STS_NO_MEMORY;
                    no_memory++;
                end
            end
            CMD_FREE: begin
                g.status = STS_NOT_FOUND;
                for (int i = 0; i < frag_used[tbl]; i++) begin
                    int a;
                    a = tbl * NFRAG + i;
                    if (!frag_free[a] && rel >= frag_base[a]
                            && 29'(rel) < 29'(frag_base[a]) + 29'(frag_len[a])) begin
                        frag_free[a] = 1;
                        g.status = STS_DONE;
                        break;
                    end
                end
                if (g.status == STS_DONE) released++;
                else not_found++;
            end
            CMD_MERGE: begin
                join_free(0);
                join_free(1);
                merges++;
            end
            default: ;
        endcase
        pending_grants = {pending_grants, g};
    endfunction

    function void check_result(bit [63:0] data);
        grant_t want, got;
        got.status = status_e_t'(data[1:0]);
        got.offset = data[29:2];
        got.size   = data[57:30];
        if (pending_grants.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %h", $time, data);
            errors++;
            return;
        end
        want = pending_grants.pop_front();
        checked++;
        if (data[63:58] != 0 || want != got) begin
            $display("%0t: mismatch, expected status %0d offset %0d size %0d, actual status %0d offset %0d size %0d (raw %h)",
                     $time, want.status, want.offset, want.size,
                     got.status, got.offset, got.size, data);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    allocator_scoreboard board;
    bit running;
    int stall_left;

    first_fit_segment_allocator_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_command(cmd_e_t cmd, bit tbl, bit [27:0] sz, bit [16:0] al,
                                bit [27:0] rel);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= {tbl, cmd};
        s_tdata  <= {7'd0, rel, al, sz};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        board.note_command(cmd, tbl, sz, al, rel);
    endtask

    function automatic bit [16:0] pick_alignment();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 17'(1 << $urandom_range(0, 16));
        if (r < 9) return 17'($urandom_range(1, 65536));
        return 17'($urandom);
    endfunction

    function automatic bit [27:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 28'($urandom_range(1, 200000));
        if (r < 18) return 28'($urandom_range(1, 16000000));
        if (r < 19) return 28'($urandom_range(16000001, 256000000));
        return 28'($urandom);
    endfunction

    task automatic random_command();
        int r, n, idx;
        bit tbl;
        bit [27:0] rel;
        r = $urandom_range(0, 99);
        tbl = $urandom_range(0, 1);
        if (r < 55) begin
            send_command(CMD_ALLOC, tbl, pick_size(), pick_alignment(), 28'($urandom));
        end else if (r < 88) begin
            n = board.live_offsets[tbl].size();
            if (n > 0 && $urandom_range(0, 9) < 8) begin
                idx = $urandom_range(0, n - 1);
                rel = board.live_offsets[tbl][idx];
                if ($urandom_range(0, 9) < 8) board.live_offsets[tbl].delete(idx);
                else rel = rel + 28'($urandom_range(0, 3));
            end else begin
                rel = 28'($urandom);
            end
            send_command(CMD_FREE, tbl, 28'($urandom), 17'($urandom), rel);
        end else if (r < 97) begin
            send_command(CMD_MERGE, tbl, 28'($urandom), 17'($urandom), 28'($urandom));
        end else begin
            send_command(CMD_NOP, tbl, 28'($urandom), 17'($urandom), 28'($urandom));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                if (running && $urandom_range(0, 9) < 3) stall_left = pick_gap();
            end
        end
    end

    initial begin
        #1500ms;
        $display("Timeout with %0d results outstanding", board.pending_grants.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        board = new();
        aresetn  <= 0;
        s_tvalid <= 0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        running = 1;

        send_command(CMD_ALLOC, 0, 28'd0, 17'd1, 28'd0);
        send_command(CMD_ALLOC, 0, 28'hFFFFFFF, 17'd1, 28'hFFFFFFF);
        send_command(CMD_ALLOC, 0, 28'd16000000, 17'd1, 28'd0);
        send_command(CMD_ALLOC, 0, 28'd1000, 17'd0, 28'd0);
        send_command(CMD_ALLOC, 0, 28'd4097, 17'd65536, 28'd0);
        send_command(CMD_ALLOC, 0, 28'd15999999, 17'd7, 28'd0);
        send_command(CMD_ALLOC, 0, 28'd500, 17'h1FFFF, 28'd0);
        send_command(CMD_ALLOC, 1, 28'd1, 17'd3, 28'd0);
        send_command(CMD_ALLOC, 1, 28'd256000000, 17'd1, 28'd0);
        send_command(CMD_FREE, 0, 28'd0, 17'd0, 28'd0);
        send_command(CMD_FREE, 0, 28'd0, 17'd0, 28'd0);
        send_command(CMD_FREE, 0, 28'd0, 17'd0, 28'hFFFFFFF);
        send_command(CMD_FREE, 1, 28'hFFFFFFF, 17'h1FFFF, 28'd255999999);
        send_command(CMD_MERGE, 0, 28'd0, 17'd0, 28'd0);
        send_command(CMD_NOP, 1, 28'hFFFFFFF, 17'h1FFFF, 28'hFFFFFFF);
        send_command(CMD_NOP, 0, 28'd0, 17'd0, 28'd0);
        repeat (80) send_command(CMD_ALLOC, 0, 28'($urandom_range(1, 5000)), 17'd1, 28'd0);
        send_command(CMD_ALLOC, 0, 28'd200000000, 17'd1, 28'd0);

        repeat (1250) random_command();

        @(posedge aclk);
        s_tvalid <= 0;
        while (board.pending_grants.size() != 0) @(posedge aclk);
        running = 0;
        repeat (100) @(posedge aclk);

        $display("Checked %0d results: %0d grants, %0d out of memory, %0d frees, %0d unmatched frees, %0d coalesces.",
                 board.checked, board.granted, board.no_memory, board.released,
                 board.not_found, board.merges);
        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
